>>> src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, disabled while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

>>> src/smbe_pkg.sv
// Shared types and constants for the SPI master byte engine
`default_nettype none

package smbe_pkg;

   localparam int DATA_BITS_DEF = 8;
   localparam int BYTE_W        = 8;
   localparam int FUNC_W        = 2;
   localparam int MODE_W        = 2;
   localparam int DIV_W         = 8;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 8;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_START    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SOFT_RST = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPI_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MSB_FIRST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLK_DIV   = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] spi_mode;
      logic              msb_first;
      logic [DIV_W-1:0]  clock_divide;
   } cfg_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [BYTE_W-1:0] tx_byte;
      logic              miso;
   } req_type;

   typedef struct packed {
      logic              sclk;
      logic              mosi;
      logic              busy_res;
      logic              starting;
      logic [BYTE_W-1:0] rx_byte;
      logic              done_res;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/smbe_csr.sv
// Configuration registers: mode, bit order, clock divider
`default_nettype none

module smbe_csr
   import smbe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SPI_MODE:  cfg_in.spi_mode     = csr_data[MODE_W-1:0];
            CSR_MSB_FIRST: cfg_in.msb_first    = csr_data[0];
            CSR_CLK_DIV:   cfg_in.clock_divide = csr_data[DIV_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> src/smbe_in_reg.sv
// Input register stage for request transfers
`default_nettype none

module smbe_in_reg
   import smbe_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  req_type   req,
   input  wire logic out_ready,
   output logic      step,
   output req_type   held
);

   logic    vld_ff, vld_in;
   req_type req_ff;
   logic    accept;

   assign req_stall = vld_ff & ~out_ready;
   assign accept    = req_valid & ~req_stall;
   assign step      = vld_ff & out_ready;
   assign vld_in    = accept | (vld_ff & ~out_ready);
   assign held      = req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
   end

endmodule

`default_nettype wire

>>> src/smbe_core.sv
// Serial engine state and one-tick update logic
`default_nettype none

module smbe_core
   import smbe_pkg::*;
#(
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step,
   input  req_type   req,
   input  cfg_type   cfg,
   output rsp_type   rsp
);

   localparam int EDGE_W = $clog2(2 * DATA_BITS + 1);
   localparam int MAXW   = (DATA_BITS > BYTE_W) ? DATA_BITS : BYTE_W;
   localparam logic [EDGE_W-1:0] EDGE_LAST = EDGE_W'(2 * DATA_BITS);
   localparam logic [EDGE_W-1:0] EDGE_ONE  = EDGE_W'(1);

   logic                 clk_lvl_ff, clk_lvl_in;
   logic [DIV_W-1:0]     half_cnt_ff, half_cnt_in;
   logic [EDGE_W-1:0]    edge_cnt_ff, edge_cnt_in;
   logic [DATA_BITS-1:0] sh_out_ff, sh_out_in;
   logic [DATA_BITS-1:0] sh_in_ff, sh_in_in;
   logic [DATA_BITS-1:0] rx_hold_ff, rx_hold_in;
   logic                 active_ff, active_in;

   logic              cpol, cpha;
   logic [DIV_W-1:0]  half, cnt_inc;
   logic [EDGE_W-1:0] edge_nxt;
   logic              starting, done;
   logic [MAXW-1:0]   tx_wide, rx_wide;
   logic              out_bit;

   assign cpol    = cfg.spi_mode[1];
   assign cpha    = cfg.spi_mode[0];
   assign half    = {1'b0, cfg.clock_divide[DIV_W-1:1]} + DIV_W'(1);
   assign cnt_inc = half_cnt_ff + DIV_W'(1);
   assign tx_wide = MAXW'(req.tx_byte);

   always_comb begin
      clk_lvl_in  = clk_lvl_ff;
      half_cnt_in = half_cnt_ff;
      edge_cnt_in = edge_cnt_ff;
      sh_out_in   = sh_out_ff;
      sh_in_in    = sh_in_ff;
      rx_hold_in  = rx_hold_ff;
      active_in   = active_ff;
      edge_nxt    = edge_cnt_ff + EDGE_ONE;
      starting    = 1'b0;
      done        = 1'b0;

      if (req.func == FUNC_SOFT_RST) begin
         clk_lvl_in  = 1'b0;
         half_cnt_in = '0;
         edge_cnt_in = '0;
         sh_out_in   = '0;
         sh_in_in    = '0;
         rx_hold_in  = '0;
         active_in   = 1'b0;
      end else if (active_ff) begin
         if (cnt_inc >= half) begin
            half_cnt_in = '0;
            clk_lvl_in  = ~clk_lvl_ff;
            edge_cnt_in = edge_nxt;
            if (edge_nxt[0] != cpha) begin
               if (cfg.msb_first) begin
                  sh_in_in = {sh_in_ff[DATA_BITS-2:0], req.miso};
               end else begin
                  sh_in_in = {req.miso, sh_in_ff[DATA_BITS-1:1]};
               end
            end else if (!cpha || edge_nxt != EDGE_ONE) begin
               if (cfg.msb_first) begin
                  sh_out_in = {sh_out_ff[DATA_BITS-2:0], 1'b0};
               end else begin
                  sh_out_in = {1'b0, sh_out_ff[DATA_BITS-1:1]};
               end
            end
            if (edge_nxt >= EDGE_LAST) begin
               rx_hold_in  = sh_in_in;
               active_in   = 1'b0;
               edge_cnt_in = '0;
               sh_out_in   = '0;
               done        = 1'b1;
            end
         end else begin
            half_cnt_in = cnt_inc;
         end
      end else if (req.func == FUNC_START) begin
         sh_out_in   = tx_wide[DATA_BITS-1:0];
         sh_in_in    = '0;
         half_cnt_in = '0;
         edge_cnt_in = '0;
         active_in   = 1'b1;
         starting    = 1'b1;
      end

      // idle clock tracks the current polarity
      if (!active_in) begin
         clk_lvl_in = cpol;
      end
   end

   assign out_bit = cfg.msb_first ? sh_out_in[DATA_BITS-1] : sh_out_in[0];
   assign rx_wide = MAXW'(rx_hold_in);

   always_comb begin
      rsp.sclk     = clk_lvl_in;
      rsp.mosi     = active_in & out_bit;
      rsp.busy_res = active_in;
      rsp.starting = starting;
      rsp.rx_byte  = rx_wide[BYTE_W-1:0];
      rsp.done_res = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_lvl_ff  <= 1'b0;
         half_cnt_ff <= '0;
         edge_cnt_ff <= '0;
         sh_out_ff   <= '0;
         sh_in_ff    <= '0;
         rx_hold_ff  <= '0;
         active_ff   <= 1'b0;
      end else if (step) begin
         clk_lvl_ff  <= clk_lvl_in;
         half_cnt_ff <= half_cnt_in;
         edge_cnt_ff <= edge_cnt_in;
         sh_out_ff   <= sh_out_in;
         sh_in_ff    <= sh_in_in;
         rx_hold_ff  <= rx_hold_in;
         active_ff   <= active_in;
      end
   end

endmodule

`default_nettype wire

>>> src/smbe_out_reg.sv
// Result register toward the response channel
`default_nettype none

module smbe_out_reg
   import smbe_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step,
   input  rsp_type   rsp_next,
   output logic      out_ready,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp
);

   logic    vld_ff, vld_in;
   rsp_type rsp_ff;

   // free when empty or the held result leaves this cycle
   assign out_ready = ~vld_ff | ~rsp_stall;
   assign vld_in    = step | (vld_ff & rsp_stall);
   assign rsp_valid = vld_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_next;
      end
   end

endmodule

`default_nettype wire

>>> src/spi_master_byte_engine.sv
// SPI master byte engine: one request transfer per system tick, one result each
//
// Each request transfer is one tick of the serial engine: func selects a plain
// tick, a start (loads tx_byte) or a soft reset; miso is the slave's line level
// for that tick. Each request yields exactly one response transfer carrying the
// sclk and mosi levels after the tick, busy, starting, done and the last
// received byte. The csr channel writes mode, bit order and clock divider; it is
// always ready and is meant to be used while no request is in flight.
// The request is first registered in the input register, then one pass of update
// logic feeds the result register, whose output drives response valid. One
// request is taken every cycle when the response side does not stall; the
// engine state advances only when a request moves into the result register.
// While rsp_stall is high the result holds, and req_stall rises once the input
// register is also occupied. Synchronous reset empties both registers, clears
// the engine state and sets all configuration registers to zero.
`default_nettype none

module spi_master_byte_engine
   import smbe_pkg::*;
#(
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [BYTE_W-1:0]     req_tx_byte,
   input  wire logic                  req_miso,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_sclk,
   output logic                       rsp_mosi,
   output logic                       rsp_busy_res,
   output logic                       rsp_starting,
   output logic [BYTE_W-1:0]          rsp_rx_byte,
   output logic                       rsp_done_res,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;
   req_type req_in, req_held;
   rsp_type rsp_next, rsp_q;
   logic    step, out_ready;

   assign req_in.func    = req_func;
   assign req_in.tx_byte = req_tx_byte;
   assign req_in.miso    = req_miso;

   smbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   smbe_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req_in),
      .out_ready (out_ready),
      .step      (step),
      .held      (req_held)
   );

   smbe_core #(
      .DATA_BITS (DATA_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_held),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   smbe_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rsp_next  (rsp_next),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp_q)
   );

   assign rsp_sclk     = rsp_q.sclk;
   assign rsp_mosi     = rsp_q.mosi;
   assign rsp_busy_res = rsp_q.busy_res;
   assign rsp_starting = rsp_q.starting;
   assign rsp_rx_byte  = rsp_q.rx_byte;
   assign rsp_done_res = rsp_q.done_res;

endmodule

`default_nettype wire

>>> src/smbe_checker.sv
// Port-level checker for the SPI master byte engine, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module smbe_checker
   import smbe_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic              rsp_mosi,
   input wire logic              rsp_busy_res,
   input wire logic              rsp_starting,
   input wire logic [BYTE_W-1:0] rsp_rx_byte,
   input wire logic              rsp_done_res
);

   `ASSERT_IMPLIES(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)
   `ASSERT_IMPLIES(a_start_busy, clock, reset, rsp_valid && rsp_starting, rsp_busy_res && !rsp_done_res)
   `ASSERT_IMPLIES(a_idle_mosi_low, clock, reset, rsp_valid && !rsp_busy_res, !rsp_mosi)
   `ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_rx_byte))
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind spi_master_byte_engine smbe_checker u_smbe_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_mosi     (rsp_mosi),
   .rsp_busy_res (rsp_busy_res),
   .rsp_starting (rsp_starting),
   .rsp_rx_byte  (rsp_rx_byte),
   .rsp_done_res (rsp_done_res)
);

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the SPI master byte engine: random and directed ticks, live predictor
`default_nettype none

module testbench;
   import smbe_pkg::*;

   localparam logic [FUNC_W-1:0]    FUNC_SPARE  = 2'd3;   // unused code, acts as a plain tick
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;   // no register behind this index
   localparam int                   IDLE_PCT    = 22;
   localparam int                   HOLD_CYCLES = 60;
   localparam int                   RANDOM_GOAL = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [FUNC_W-1:0]     req_func = FUNC_TICK;
   logic [BYTE_W-1:0]     req_tx_byte = '0;
   logic                  req_miso = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_sclk;
   logic                  rsp_mosi;
   logic                  rsp_busy_res;
   logic                  rsp_starting;
   logic [BYTE_W-1:0]     rsp_rx_byte;
   logic                  rsp_done_res;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   spi_master_byte_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_tx_byte(req_tx_byte), .req_miso(req_miso),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sclk(rsp_sclk),
      .rsp_mosi(rsp_mosi), .rsp_busy_res(rsp_busy_res), .rsp_starting(rsp_starting),
      .rsp_rx_byte(rsp_rx_byte), .rsp_done_res(rsp_done_res),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // engine model: configuration and serial state
   logic [MODE_W-1:0] eng_mode = '0;
   logic              eng_msb_first = 1'b0;
   logic [DIV_W-1:0]  eng_div = '0;
   logic              eng_level = 1'b0;
   logic [7:0]        eng_half_cnt = '0;
   logic [4:0]        eng_edges = '0;
   logic [BYTE_W-1:0] eng_sh_out = '0;
   logic [BYTE_W-1:0] eng_sh_in = '0;
   logic [BYTE_W-1:0] eng_rx_hold = '0;
   logic              eng_active = 1'b0;
   logic              eng_started = 1'b0;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      reqs_queued = 0;
   int      reqs_accepted = 0;
   int      rsps_checked = 0;
   int      starts_taken = 0;
   int      dones_seen = 0;
   int      errors = 0;
   int      random_items = 0;
   int      phases = 0;
   logic    req_taken = 1'b0;
   logic    gaps_on = 1'b1;
   int      holds_asked = 0;

   function automatic void clear_engine();
      eng_level    = 1'b0;
      eng_half_cnt = '0;
      eng_edges    = '0;
      eng_sh_out   = '0;
      eng_sh_in    = '0;
      eng_rx_hold  = '0;
      eng_active   = 1'b0;
      eng_started  = 1'b0;
   endfunction

   // advance the engine by one system tick and return the levels after it
   function automatic rsp_type spi_tick(input req_type r);
      rsp_type res;
      logic    cpol;
      logic    cpha;
      int      half;
      logic    done;
      cpol = eng_mode[1];
      cpha = eng_mode[0];
      half = (int'(eng_div) >> 1) + 1;
      done = 1'b0;
      eng_started = 1'b0;
      if (r.func == FUNC_SOFT_RST) begin
         clear_engine();
      end else if (eng_active) begin
         // starts while busy land here and are dropped
         eng_half_cnt = eng_half_cnt + 8'd1;
         if (int'(eng_half_cnt) >= half) begin
            eng_half_cnt = '0;
            eng_level = ~eng_level;
            eng_edges = eng_edges + 5'd1;
            if (eng_edges[0] != cpha) begin
               if (eng_msb_first) eng_sh_in = {eng_sh_in[BYTE_W-2:0], r.miso};
               else eng_sh_in = {r.miso, eng_sh_in[BYTE_W-1:1]};
            end else if (!cpha || eng_edges != 5'd1) begin
               if (eng_msb_first) eng_sh_out = {eng_sh_out[BYTE_W-2:0], 1'b0};
               else eng_sh_out = {1'b0, eng_sh_out[BYTE_W-1:1]};
            end
            if (int'(eng_edges) >= 2 * BYTE_W) begin
               eng_rx_hold  = eng_sh_in;
               eng_active   = 1'b0;
               eng_edges    = '0;
               eng_half_cnt = '0;
               eng_sh_out   = '0;
               done         = 1'b1;
            end
         end
      end else if (r.func == FUNC_START) begin
         eng_sh_out   = r.tx_byte;
         eng_sh_in    = '0;
         eng_half_cnt = '0;
         eng_edges    = '0;
         eng_active   = 1'b1;
         eng_started  = 1'b1;
      end
      if (!eng_active) eng_level = cpol;
      res.sclk     = eng_level;
      res.mosi     = eng_active ? (eng_msb_first ? eng_sh_out[BYTE_W-1] : eng_sh_out[0]) : 1'b0;
      res.busy_res = eng_active;
      res.starting = eng_started;
      res.rx_byte  = eng_rx_hold;
      res.done_res = done;
      return res;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // request driver: new transfer offered at the falling edge once the last one is taken
   always @(negedge clock) begin : drive_req
      req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() != 0 && !(gaps_on && $urandom_range(99) < IDLE_PCT)) begin
            nxt = pending_reqs.pop_front();
            req_valid   <= 1'b1;
            req_func    <= nxt.func;
            req_tx_byte <= nxt.tx_byte;
            req_miso    <= nxt.miso;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall driver, with long hold-offs on request
   always @(negedge clock) begin : drive_rsp_stall
      int hold_left;
      int holds_served;
      if (reset) begin
         hold_left = 0;
         holds_served = 0;
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_served < holds_asked) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // monitor: register writes, request transfers into the model, result checks
   always @(posedge clock) begin : monitor
      rsp_type want;
      req_type got_req;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SPI_MODE:  eng_mode = csr_data[MODE_W-1:0];
               CSR_MSB_FIRST: eng_msb_first = csr_data[0];
               CSR_CLK_DIV:   eng_div = csr_data[DIV_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: result with none expected, expected nothing actual %0h",
                        $time, {rsp_sclk, rsp_mosi, rsp_busy_res, rsp_starting,
                                rsp_rx_byte, rsp_done_res});
            end else begin
               want = expected_rsps.pop_front();
               rsps_checked++;
               check_field("sclk", 32'(want.sclk), 32'(rsp_sclk));
               check_field("mosi", 32'(want.mosi), 32'(rsp_mosi));
               check_field("busy", 32'(want.busy_res), 32'(rsp_busy_res));
               check_field("starting", 32'(want.starting), 32'(rsp_starting));
               check_field("rx_byte", 32'(want.rx_byte), 32'(rsp_rx_byte));
               check_field("done", 32'(want.done_res), 32'(rsp_done_res));
            end
         end
         if (req_valid && !req_stall) begin
            got_req.func    = req_func;
            got_req.tx_byte = req_tx_byte;
            got_req.miso    = req_miso;
            want = spi_tick(got_req);
            expected_rsps.push_back(want);
            reqs_accepted++;
            if (want.starting) starts_taken++;
            if (want.done_res) dones_seen++;
         end
      end
   end

   task automatic push_req(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] tx,
                           input logic miso);
      req_type r;
      r.func = func;
      r.tx_byte = tx;
      r.miso = miso;
      pending_reqs.push_back(r);
      reqs_queued++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [MODE_W-1:0] mode, input logic msb,
                            input logic [DIV_W-1:0] div);
      write_reg(CSR_SPI_MODE, {6'($urandom), mode});
      write_reg(CSR_MSB_FIRST, {7'($urandom), msb});
      write_reg(CSR_CLK_DIV, div);
   endtask

   // sender holds off until every accepted transfer has produced its result
   task automatic settle();
      do @(negedge clock);
      while (reqs_accepted != reqs_queued || expected_rsps.size() != 0);
      repeat (3) @(negedge clock);
      phases++;
   endtask

   // one start and enough ticks to finish it, with random noise and an occasional abort
   task automatic push_transfer(input int ticks);
      int cut;
      int pick;
      cut = ($urandom_range(9) == 0) ? $urandom_range(1, ticks) : -1;
      push_req(FUNC_START, 8'($urandom), 1'($urandom));
      random_items++;
      for (int i = 1; i <= ticks + $urandom_range(3); i++) begin
         pick = $urandom_range(99);
         if (i == cut) push_req(FUNC_SOFT_RST, 8'($urandom), 1'($urandom));
         else if (pick < 4) push_req(FUNC_SPARE, 8'($urandom), 1'($urandom));
         else if (pick < 8) push_req(FUNC_START, 8'($urandom), 1'($urandom));
         else push_req(FUNC_TICK, 8'($urandom), 1'($urandom));
         random_items++;
      end
   endtask

   initial begin : stimulus
      logic [DIV_W-1:0] div;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: unused register write, spare code, start, start while busy, full transfer, abort
      write_reg(CSR_UNUSED, 8'hA7);
      configure(2'd0, 1'b1, 8'd0);
      push_req(FUNC_SPARE, 8'h00, 1'b0);
      push_req(FUNC_START, 8'hFF, 1'b1);
      push_req(FUNC_START, 8'h00, 1'b0);
      for (int i = 0; i < 15; i++) push_req(FUNC_TICK, 8'($urandom), 1'(i));
      push_req(FUNC_START, 8'h5A, 1'b1);
      repeat (5) push_req(FUNC_TICK, 8'hFF, 1'b1);
      push_req(FUNC_SOFT_RST, 8'hFF, 1'b1);
      push_req(FUNC_TICK, 8'h00, 1'b0);
      settle();

      // long receiver hold-off while the sender keeps offering
      configure(2'd3, 1'b0, 8'd2);
      holds_asked++;
      repeat (4) push_transfer(2 * BYTE_W * 2);
      settle();

      // slowest divider: partial transfer, then abort
      configure(2'd2, 1'b1, 8'd255);
      push_transfer(280);
      push_req(FUNC_SOFT_RST, 8'($urandom), 1'($urandom));
      push_req(FUNC_TICK, 8'($urandom), 1'($urandom));
      settle();

      while (random_items < RANDOM_GOAL) begin
         // first random phase runs with no idling on either side
         gaps_on = (phases != 3);
         div = ($urandom_range(7) == 0) ? DIV_W'($urandom_range(8, 15))
                                        : DIV_W'($urandom_range(0, 5));
         if ($urandom_range(3) == 0) write_reg(CSR_UNUSED, 8'($urandom));
         configure(MODE_W'($urandom), 1'($urandom), div);
         repeat ((int'(div) > 5) ? 1 : $urandom_range(2, 5))
            push_transfer(2 * BYTE_W * ((int'(div) >> 1) + 1));
         if (!gaps_on) repeat (3) push_transfer(2 * BYTE_W * ((int'(div) >> 1) + 1));
         // leave a transfer running so the next register writes land mid-transfer
         if ($urandom_range(1) == 0) begin
            push_req(FUNC_START, 8'($urandom), 1'($urandom));
            repeat ($urandom_range(10)) push_req(FUNC_TICK, 8'($urandom), 1'($urandom));
         end
         settle();
      end

      repeat (6) @(negedge clock);
      if (expected_rsps.size() != 0) errors++;
      $display("Covered %0d ticks in %0d phases, %0d results checked", reqs_accepted,
               phases, rsps_checked);
      $display("Transfers started %0d, completed %0d, mismatches %0d", starts_taken,
               dones_seen, errors);
      if (errors == 0) begin
         $display("PASS spi_master_byte_engine");
      end else begin
         $display("FAIL spi_master_byte_engine");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("FAIL spi_master_byte_engine");
      $finish;
   end

endmodule

`default_nettype wire
